>>> hw/rtl/plt_pkg.sv
// ----------------------------------------------------------------------------
// plt_pkg
// Shared types, constants and helpers for the pressure level tracker.
// ----------------------------------------------------------------------------
package plt_pkg;

  localparam int unsigned NODES   = 8;
  localparam int unsigned NODE_W  = 3;
  localparam int unsigned TIME_W  = 64;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned CFG_W   = 64;
  localparam int unsigned CIDX_W  = 3;

  // pressure levels
  localparam logic [1:0] LV_OK   = 2'd0;
  localparam logic [1:0] LV_SOFT = 2'd1;
  localparam logic [1:0] LV_HARD = 2'd2;
  localparam logic [1:0] LV_CRIT = 2'd3;

  // event causes
  localparam logic [1:0] CAUSE_WAKE  = 2'd0;
  localparam logic [1:0] CAUSE_BAL   = 2'd1;
  localparam logic [1:0] CAUSE_DIR   = 2'd2;
  localparam logic [1:0] CAUSE_OTHER = 2'd3;
  localparam logic [1:0] CAUSE_QUIET = 2'd3;

  // item kinds
  localparam logic FUNC_EVENT = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  // register indexes
  localparam logic [CIDX_W-1:0] REG_SOFT_WIN  = 3'd0;
  localparam logic [CIDX_W-1:0] REG_HARD_WIN  = 3'd1;
  localparam logic [CIDX_W-1:0] REG_THRESH    = 3'd2;
  localparam logic [CIDX_W-1:0] REG_REC_WAKE  = 3'd3;
  localparam logic [CIDX_W-1:0] REG_REC_BAL   = 3'd4;
  localparam logic [CIDX_W-1:0] REG_HOLD_CRIT = 3'd5;
  localparam logic [CIDX_W-1:0] REG_HOLD_HARD = 3'd6;
  localparam logic [CIDX_W-1:0] REG_HOLD_SOFT = 3'd7;

  // controller to datapath
  typedef struct packed {
    logic              latch;
    logic              ev_step;
    logic              walk_step;
    logic [NODE_W-1:0] idx;
    logic              emit_last;
  } plt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_tick;
    logic skip;
  } plt_sts_t;

  // elapsed time, floored at zero
  function automatic logic [TIME_W-1:0] age(input logic [TIME_W-1:0] now,
                                            input logic [TIME_W-1:0] then_t);
    age = (now >= then_t) ? (now - then_t) : '0;
  endfunction

endpackage

>>> hw/rtl/plt_if.sv
// ----------------------------------------------------------------------------
// plt channel interfaces
// Input, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface plt_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [2:0]  node;
  logic [1:0]  cause;
  logic [63:0] timestamp;
  modport source (output valid, func, node, cause, timestamp, input ready);
  modport sink   (input valid, func, node, cause, timestamp, output ready);
endinterface

interface plt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  result_node;
  logic [1:0]  old_level;
  logic [1:0]  new_level;
  logic        changed;
  logic [1:0]  result_cause;
  logic [63:0] result_time;
  logic [1:0]  highest_level;
  logic        last;
  modport source (output valid, result_node, old_level, new_level, changed, result_cause,
                  result_time, highest_level, last, input ready);
  modport sink   (input valid, result_node, old_level, new_level, changed, result_cause,
                  result_time, highest_level, last, output ready);
endinterface

interface plt_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/plt_ctrl.sv
// ----------------------------------------------------------------------------
// plt_ctrl
// Sequencer: decode, node walk and result emission.
// ----------------------------------------------------------------------------
module plt_ctrl import plt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  plt_sts_t sts_i,
  output plt_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECODE = 2'd1;
  localparam logic [1:0] S_WALK   = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [NODE_W-1:0] idx_q, idx_d;
  logic              tick_q, tick_d;
  logic              last_node;
  logic              emit_last;

  assign last_node = (idx_q == NODE_W'(NODES - 1));
  assign emit_last = tick_q ? last_node : 1'b1;

  // next state
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    tick_d  = tick_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        idx_d  = '0;
        tick_d = sts_i.is_tick;
        if (sts_i.is_tick) state_d = S_WALK;
        else if (sts_i.skip) state_d = S_IDLE;
        else state_d = S_EMIT;
      end
      S_WALK: begin
        if (last_node) begin
          state_d = S_EMIT;
          idx_d   = '0;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_EMIT: begin
        if (out_ready_i) begin
          if (emit_last) state_d = S_IDLE;
          else idx_d = idx_q + 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      tick_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      tick_q  <= tick_d;
    end
  end

  // handshakes and commands
  assign in_ready_o       = (state_q == S_IDLE);
  assign out_valid_o      = (state_q == S_EMIT);
  assign cmd_o.latch      = in_valid_i && (state_q == S_IDLE);
  assign cmd_o.ev_step    = (state_q == S_DECODE) && !sts_i.is_tick && !sts_i.skip;
  assign cmd_o.walk_step  = (state_q == S_WALK);
  assign cmd_o.idx        = idx_q;
  assign cmd_o.emit_last  = emit_last;

  // checks
  a_not_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("input taken while results pending");
  a_event_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !tick_q) |-> (idx_q == '0)) else $error("event emits more than one");
  a_walk_to_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK && last_node) |=> out_valid_o) else $error("walk did not emit");
  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && emit_last) |=> in_ready_o) else $error("no return to idle");

endmodule

>>> hw/rtl/plt_dp.sv
// ----------------------------------------------------------------------------
// plt_dp
// Per-node state, configuration registers, update logic and result buffer.
// ----------------------------------------------------------------------------
module plt_dp import plt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // item
  input  logic               func_i,
  input  logic [NODE_W-1:0]  node_i,
  input  logic [1:0]         cause_i,
  input  logic [TIME_W-1:0]  timestamp_i,
  // configuration
  input  logic               cfg_we_i,
  input  logic [CIDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]   cfg_data_i,
  // control
  input  plt_cmd_t           cmd_i,
  output plt_sts_t           sts_o,
  // result payload
  output logic [NODE_W-1:0]  result_node_o,
  output logic [1:0]         old_level_o,
  output logic [1:0]         new_level_o,
  output logic               changed_o,
  output logic [1:0]         result_cause_o,
  output logic [TIME_W-1:0]  result_time_o,
  output logic [1:0]         highest_level_o,
  output logic               last_o
);

  // configuration registers
  logic [TIME_W-1:0] soft_win_q, hard_win_q, rec_wake_q, rec_bal_q;
  logic [TIME_W-1:0] hold_crit_q, hold_hard_q, hold_soft_q;
  logic [31:0]       thresh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      soft_win_q  <= 64'd1000000000;
      hard_win_q  <= 64'd1000000000;
      thresh_q    <= 32'd196611;
      rec_wake_q  <= 64'd5000000000;
      rec_bal_q   <= 64'd5000000000;
      hold_crit_q <= 64'd10000000000;
      hold_hard_q <= 64'd10000000000;
      hold_soft_q <= 64'd10000000000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SOFT_WIN:  soft_win_q  <= cfg_data_i;
        REG_HARD_WIN:  hard_win_q  <= cfg_data_i;
        REG_THRESH:    thresh_q    <= cfg_data_i[31:0];
        REG_REC_WAKE:  rec_wake_q  <= cfg_data_i;
        REG_REC_BAL:   rec_bal_q   <= cfg_data_i;
        REG_HOLD_CRIT: hold_crit_q <= cfg_data_i;
        REG_HOLD_HARD: hold_hard_q <= cfg_data_i;
        REG_HOLD_SOFT: hold_soft_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // latched item
  logic              func_q;
  logic [NODE_W-1:0] node_q;
  logic [1:0]        cause_q;
  logic [TIME_W-1:0] now_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      func_q  <= func_i;
      node_q  <= node_i;
      cause_q <= cause_i;
      now_q   <= timestamp_i;
    end
  end

  assign sts_o.is_tick = (func_q == FUNC_TICK);
  assign sts_o.skip    = (32'(node_q) >= 32'(NODES)) || (cause_q == CAUSE_OTHER);

  // node state
  logic [1:0]        level_q   [NODES];
  logic [TIME_W-1:0] lwake_q   [NODES];
  logic [TIME_W-1:0] lbal_q    [NODES];
  logic [TIME_W-1:0] ldir_q    [NODES];
  logic [TIME_W-1:0] wstart_q  [NODES];
  logic [CNT_W-1:0]  wcnt_q    [NODES];
  logic [TIME_W-1:0] bstart_q  [NODES];
  logic [CNT_W-1:0]  bcnt_q    [NODES];

  // working node: event node or walk index
  logic [NODE_W-1:0] sel;
  assign sel = cmd_i.walk_step ? cmd_i.idx : node_q;

  logic [1:0]        cur_lv;
  logic [TIME_W-1:0] cur_lwake, cur_lbal, cur_ldir, cur_wstart, cur_bstart;
  logic [CNT_W-1:0]  cur_wcnt, cur_bcnt;

  assign cur_lv     = level_q[sel];
  assign cur_lwake  = lwake_q[sel];
  assign cur_lbal   = lbal_q[sel];
  assign cur_ldir   = ldir_q[sel];
  assign cur_wstart = wstart_q[sel];
  assign cur_bstart = bstart_q[sel];
  assign cur_wcnt   = wcnt_q[sel];
  assign cur_bcnt   = bcnt_q[sel];

  // event burst tracking
  logic              w_restart, b_restart;
  logic [CNT_W-1:0]  w_cnt_n, b_cnt_n;
  logic [1:0]        ev_lv;

  assign w_restart = (cur_wcnt == '0) || (age(now_q, cur_wstart) > soft_win_q);
  assign b_restart = (cur_bcnt == '0) || (age(now_q, cur_bstart) > hard_win_q);
  assign w_cnt_n   = w_restart ? CNT_W'(1) : (&cur_wcnt ? cur_wcnt : cur_wcnt + 1'b1);
  assign b_cnt_n   = b_restart ? CNT_W'(1) : (&cur_bcnt ? cur_bcnt : cur_bcnt + 1'b1);

  always_comb begin
    ev_lv = cur_lv;
    case (cause_q)
      CAUSE_WAKE: if (cur_lv < LV_SOFT && w_cnt_n >= thresh_q[15:0]) ev_lv = LV_SOFT;
      CAUSE_BAL:  if (cur_lv < LV_HARD && b_cnt_n >= thresh_q[31:16]) ev_lv = LV_HARD;
      CAUSE_DIR:  ev_lv = LV_CRIT;
      default:    ev_lv = cur_lv;
    endcase
  end

  // decay check on tick
  logic [1:0] fb_lv, dec_lv;
  logic       held_out;

  assign fb_lv = (age(now_q, cur_lbal) < rec_bal_q)  ? LV_HARD :
                 (age(now_q, cur_lwake) < rec_wake_q) ? LV_SOFT : LV_OK;

  always_comb begin
    case (cur_lv)
      LV_CRIT: held_out = age(now_q, cur_ldir)  >= hold_crit_q;
      LV_HARD: held_out = age(now_q, cur_lbal)  >= hold_hard_q;
      LV_SOFT: held_out = age(now_q, cur_lwake) >= hold_soft_q;
      default: held_out = 1'b0;
    endcase
    dec_lv = held_out ? fb_lv : cur_lv;
  end

  // state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NODES; i++) begin
        level_q[i]  <= LV_OK;
        lwake_q[i]  <= '0;
        lbal_q[i]   <= '0;
        ldir_q[i]   <= '0;
        wstart_q[i] <= '0;
        wcnt_q[i]   <= '0;
        bstart_q[i] <= '0;
        bcnt_q[i]   <= '0;
      end
    end else if (cmd_i.ev_step) begin
      level_q[sel] <= ev_lv;
      case (cause_q)
        CAUSE_WAKE: begin
          lwake_q[sel] <= now_q;
          wcnt_q[sel]  <= w_cnt_n;
          if (w_restart) wstart_q[sel] <= now_q;
        end
        CAUSE_BAL: begin
          lbal_q[sel] <= now_q;
          bcnt_q[sel] <= b_cnt_n;
          if (b_restart) bstart_q[sel] <= now_q;
        end
        default: ldir_q[sel] <= now_q;
      endcase
    end else if (cmd_i.walk_step && dec_lv != cur_lv) begin
      level_q[sel] <= dec_lv;
      if (dec_lv < LV_SOFT) begin
        wcnt_q[sel]   <= '0;
        wstart_q[sel] <= '0;
      end
      if (dec_lv < LV_HARD) begin
        bcnt_q[sel]   <= '0;
        bstart_q[sel] <= '0;
      end
    end
  end

  // result buffer, one entry per node on a tick; an event uses entry 0
  logic [NODE_W-1:0] rb_node_q [NODES];
  logic [1:0]        rb_old_q  [NODES];
  logic [1:0]        rb_new_q  [NODES];

  always_ff @(posedge clk_i) begin
    if (cmd_i.ev_step) begin
      rb_node_q[0] <= node_q;
      rb_old_q[0]  <= cur_lv;
      rb_new_q[0]  <= ev_lv;
    end else if (cmd_i.walk_step) begin
      rb_node_q[sel] <= sel;
      rb_old_q[sel]  <= cur_lv;
      rb_new_q[sel]  <= dec_lv;
    end
  end

  // highest level over all nodes
  always_comb begin
    highest_level_o = LV_OK;
    for (int i = 0; i < NODES; i++)
      if (level_q[i] > highest_level_o) highest_level_o = level_q[i];
  end

  assign result_node_o  = rb_node_q[cmd_i.idx];
  assign old_level_o    = rb_old_q[cmd_i.idx];
  assign new_level_o    = rb_new_q[cmd_i.idx];
  assign changed_o      = (old_level_o != new_level_o);
  assign result_cause_o = (func_q == FUNC_TICK) ? CAUSE_QUIET : cause_q;
  assign result_time_o  = now_q;
  assign last_o         = cmd_i.emit_last;

endmodule

>>> hw/rtl/pressure_level_tracker.sv
// ----------------------------------------------------------------------------
// pressure_level_tracker
// Per-node memory pressure level tracker, top level.
// ----------------------------------------------------------------------------
// One item is handled at a time. An event is latched on acceptance, then
// its node state is updated, and its single result is offered and held
// while the sink stalls. A tick is latched and decoded; the controller then
// walks the eight nodes one per cycle through a single decay unit, then
// emits the eight buffered results one per cycle while the sink is ready, so
// highest_level on each reflects the state after the whole walk. Events with
// cause 3 give no result and the block returns to idle from decode.
// Configuration writes are taken every cycle and must occur only while idle.
module pressure_level_tracker import plt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  plt_in_if.sink    in_i,
  plt_out_if.source out_o,
  plt_cfg_if.sink   cfg_i
);

  plt_cmd_t cmd;
  plt_sts_t sts;

  assign cfg_i.ready = 1'b1;

  // sequencer
  plt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath
  plt_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .func_i          (in_i.func),
    .node_i          (in_i.node),
    .cause_i         (in_i.cause),
    .timestamp_i     (in_i.timestamp),
    .cfg_we_i        (cfg_i.valid),
    .cfg_idx_i       (cfg_i.index),
    .cfg_data_i      (cfg_i.data),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .result_node_o   (out_o.result_node),
    .old_level_o     (out_o.old_level),
    .new_level_o     (out_o.new_level),
    .changed_o       (out_o.changed),
    .result_cause_o  (out_o.result_cause),
    .result_time_o   (out_o.result_time),
    .highest_level_o (out_o.highest_level),
    .last_o          (out_o.last)
  );

endmodule
